/* hw/rtl/fsm_core_pkg.sv */
// Shared types, constants and helpers of the Forth stack machine core.
package fsm_core_pkg;

	localparam int MEM_WORDS = 8192;
	localparam int AW        = $clog2(MEM_WORDS);

	localparam logic [15:0] DS_BASE_CELL = 16'd6;
	localparam logic [15:0] RS_BASE_CELL = 16'd7;
	localparam logic [15:0] DS_PTR_CELL  = 16'd33;
	localparam logic [15:0] RS_PTR_CELL  = 16'd34;
	localparam logic [15:0] DS_RESET     = 16'd35;
	localparam logic [15:0] RS_RESET     = 16'd99;
	localparam logic [15:0] WORD_TRUE    = 16'hFFFF;
	localparam logic [15:0] SIGN_BIT     = 16'h8000;
	localparam logic [15:0] MEM_SIZE_W   = 16'(MEM_WORDS);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STEP  = 2'd3;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_STOP = 2'd2;

	localparam logic [15:0] I_NOP     = 16'd0;
	localparam logic [15:0] I_HALT    = 16'd1;
	localparam logic [15:0] I_LIT     = 16'd2;
	localparam logic [15:0] I_EXIT    = 16'd3;
	localparam logic [15:0] I_LOAD    = 16'd4;
	localparam logic [15:0] I_STORE   = 16'd5;
	localparam logic [15:0] I_DROP    = 16'd6;
	localparam logic [15:0] I_OVER    = 16'd7;
	localparam logic [15:0] I_SWAP    = 16'd8;
	localparam logic [15:0] I_DUP     = 16'd9;
	localparam logic [15:0] I_UMPLUS  = 16'd10;
	localparam logic [15:0] I_NAND    = 16'd11;
	localparam logic [15:0] I_ZLESS   = 16'd12;
	localparam logic [15:0] I_TOR     = 16'd13;
	localparam logic [15:0] I_RFROM   = 16'd14;
	localparam logic [15:0] I_NEXT    = 16'd15;
	localparam logic [15:0] I_BRANCH  = 16'd16;
	localparam logic [15:0] I_ZBRANCH = 16'd17;
	localparam logic [15:0] I_EXECUTE = 16'd18;
	localparam logic [15:0] I_PUTC    = 16'd19;
	localparam logic [15:0] I_GETC    = 16'd20;

	localparam logic [2:0] U_END  = 3'd0;
	localparam logic [2:0] U_RD   = 3'd1;
	localparam logic [2:0] U_WR   = 3'd2;
	localparam logic [2:0] U_PUSH = 3'd3;
	localparam logic [2:0] U_POP  = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [15:0] wdata;
		logic [7:0]  in_char;
		logic        in_eof;
	} in_item_t;

	typedef struct packed {
		logic [15:0] rdata;
		logic [15:0] pc_now;
		logic [1:0]  status;
		logic        out_valid;
		logic [7:0]  out_char;
		logic        char_taken;
	} res_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        rs;
		logic        dst_b;
		logic [15:0] addr;
		logic [15:0] val;
	} uop_t;

	function automatic uop_t mk_uop(logic [2:0] kind, logic rs, logic dst_b,
			logic [15:0] addr, logic [15:0] val);
		uop_t u;
		u.kind  = kind;
		u.rs    = rs;
		u.dst_b = dst_b;
		u.addr  = addr;
		u.val   = val;
		return u;
	endfunction

endpackage

/* hw/rtl/forth_stack_machine_core.sv */
// Top level of the Forth stack machine core: shared word memory and micro-sequencer.
// One item per transaction; code, both stacks and the pointer cells live in one
// single-port RAM, so each item walks through one word access per cycle. A memory
// write or read takes one RAM access, a start one return stack push, and a step
// that finds the machine not running none; a running step fetches its word, then
// runs its micro-ops in turn, each stack push or pop touching its pointer cell and
// the stack cell, each plain access one word, and then finishes. A held result adds
// its stall before the next item is taken. After reset the block clears the RAM
// and is not ready until that pass ends.
module forth_stack_machine_core import fsm_core_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_MWR    = 5'd2;
	localparam logic [4:0] S_MRD    = 5'd3;
	localparam logic [4:0] S_MRD2   = 5'd4;
	localparam logic [4:0] S_FETCH0 = 5'd5;
	localparam logic [4:0] S_FETCH1 = 5'd6;
	localparam logic [4:0] S_DISP   = 5'd7;
	localparam logic [4:0] S_R0     = 5'd8;
	localparam logic [4:0] S_R1     = 5'd9;
	localparam logic [4:0] S_W0     = 5'd10;
	localparam logic [4:0] S_U0     = 5'd11;
	localparam logic [4:0] S_U1     = 5'd12;
	localparam logic [4:0] S_U2     = 5'd13;
	localparam logic [4:0] S_U3     = 5'd14;
	localparam logic [4:0] S_O0     = 5'd15;
	localparam logic [4:0] S_O1     = 5'd16;
	localparam logic [4:0] S_O2     = 5'd17;
	localparam logic [4:0] S_O3     = 5'd18;
	localparam logic [4:0] S_O4     = 5'd19;
	localparam logic [4:0] S_FIN    = 5'd20;
	localparam logic [4:0] S_OUT    = 5'd21;

	localparam logic [1:0] M_NONE  = 2'd0;
	localparam logic [1:0] M_STEP  = 2'd1;
	localparam logic [1:0] M_START = 2'd2;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rd_q;

	logic [4:0]    state_q;
	logic [1:0]    mode_q;
	logic [2:0]    k_q;
	logic [AW-1:0] clr_q;
	logic [15:0]   w_q, a_q, b_q, pc_q, rdata_q;
	logic [1:0]    stat_q;
	in_item_t      item_q;
	logic          res_valid_q;
	res_item_t     res_q;

	uop_t        u;
	logic [15:0] ptr_cell, pc1, pc2, getc_val, pcn;
	logic [16:0] sum;
	logic        mem_we;
	logic [15:0] mem_a, mem_wd;
	logic [15:0] clr_val;

	assign pc1      = pc_q + 16'd1;
	assign pc2      = pc_q + 16'd2;
	assign sum      = {1'b0, a_q} + {1'b0, b_q};
	assign getc_val = item_q.in_eof ? WORD_TRUE : {8'd0, item_q.in_char};
	assign ptr_cell = u.rs ? RS_PTR_CELL : DS_PTR_CELL;

	always_comb begin
		u = mk_uop(U_END, 1'b0, 1'b0, 16'd0, 16'd0);
		if (mode_q == M_START) begin
			if (k_q == 3'd0) u = mk_uop(U_PUSH, 1'b1, 1'b0, 16'd0, MEM_SIZE_W);
		end else begin
			unique case (w_q)
				I_NOP, I_HALT: u = mk_uop(U_END, 1'b0, 1'b0, 16'd0, 16'd0);
				I_LIT: begin
					if (k_q == 3'd0) u = mk_uop(U_RD, 1'b0, 1'b0, pc1, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
				end
				I_EXIT: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b1, 1'b0, 16'd0, 16'd0);
				end
				I_LOAD: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_RD, 1'b0, 1'b0, a_q, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
				end
				I_STORE: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_WR, 1'b0, 1'b0, a_q, b_q);
				end
				I_DROP, I_PUTC: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
				end
				I_OVER: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, b_q);
					else if (k_q == 3'd3) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
					else if (k_q == 3'd4) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, b_q);
				end
				I_SWAP: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
					else if (k_q == 3'd3) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, b_q);
				end
				I_DUP: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1 || k_q == 3'd2)
						u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
				end
				I_UMPLUS: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, sum[15:0]);
					else if (k_q == 3'd3)
						u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, {15'd0, sum[16]});
				end
				I_NAND: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, ~(a_q & b_q));
				end
				I_ZLESS: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1)
						u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0,
							((a_q & SIGN_BIT) != 16'd0) ? WORD_TRUE : 16'd0);
				end
				I_TOR: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_PUSH, 1'b1, 1'b0, 16'd0, a_q);
				end
				I_RFROM: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b1, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, a_q);
				end
				I_NEXT: begin
					if (k_q == 3'd0) u = mk_uop(U_RD, 1'b0, 1'b0, pc1, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b1, 1'b1, 16'd0, 16'd0);
					else if (k_q == 3'd2 && b_q != 16'd0)
						u = mk_uop(U_PUSH, 1'b1, 1'b0, 16'd0, b_q - 16'd1);
				end
				I_BRANCH: begin
					if (k_q == 3'd0) u = mk_uop(U_RD, 1'b0, 1'b0, pc1, 16'd0);
				end
				I_ZBRANCH: begin
					if (k_q == 3'd0) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
					else if (k_q == 3'd1) u = mk_uop(U_RD, 1'b0, 1'b1, pc1, 16'd0);
				end
				I_EXECUTE: begin
					if (k_q == 3'd0) u = mk_uop(U_PUSH, 1'b1, 1'b0, 16'd0, pc1);
					else if (k_q == 3'd1) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
				end
				I_GETC: begin
					if (k_q == 3'd0) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, getc_val);
					else if (k_q == 3'd1) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, WORD_TRUE);
				end
				default: begin
					// call
					if (k_q == 3'd0) u = mk_uop(U_PUSH, 1'b0, 1'b0, 16'd0, w_q);
					else if (k_q == 3'd1) u = mk_uop(U_PUSH, 1'b1, 1'b0, 16'd0, pc1);
					else if (k_q == 3'd2) u = mk_uop(U_POP, 1'b0, 1'b0, 16'd0, 16'd0);
				end
			endcase
		end
	end

	always_comb begin
		unique case (w_q)
			I_HALT:                      pcn = pc_q;
			I_LIT:                       pcn = pc2;
			I_EXIT, I_BRANCH, I_EXECUTE: pcn = a_q;
			I_NEXT:                      pcn = (b_q == 16'd0) ? pc2 : a_q;
			I_ZBRANCH:                   pcn = (a_q == 16'd0) ? b_q : pc2;
			I_NOP, I_LOAD, I_STORE, I_DROP, I_OVER, I_SWAP, I_DUP, I_UMPLUS,
			I_NAND, I_ZLESS, I_TOR, I_RFROM, I_PUTC, I_GETC: pcn = pc1;
			default:                     pcn = a_q;
		endcase
	end

	always_comb begin
		if (clr_q == AW'(DS_BASE_CELL) || clr_q == AW'(DS_PTR_CELL))      clr_val = DS_RESET;
		else if (clr_q == AW'(RS_BASE_CELL) || clr_q == AW'(RS_PTR_CELL)) clr_val = RS_RESET;
		else                                                              clr_val = 16'd0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_a  = ptr_cell;
		mem_wd = 16'd0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_a  = 16'(clr_q);
				mem_wd = clr_val;
			end
			S_MWR: begin
				mem_we = 1'b1;
				mem_a  = item_q.addr;
				mem_wd = item_q.wdata;
			end
			S_MRD:    mem_a = item_q.addr;
			S_FETCH0: mem_a = pc_q;
			S_R0:     mem_a = u.addr;
			S_W0: begin
				mem_we = 1'b1;
				mem_a  = u.addr;
				mem_wd = u.val;
			end
			S_U1: begin
				mem_we = 1'b1;
				mem_a  = rd_q;
				mem_wd = u.val;
			end
			S_U3: begin
				mem_we = 1'b1;
				mem_wd = u.rs ? rd_q - 16'd1 : rd_q + 16'd1;
			end
			S_O1: begin
				mem_we = 1'b1;
				mem_wd = u.rs ? rd_q + 16'd1 : rd_q - 16'd1;
			end
			S_O3: mem_a = rd_q;
			default: mem_a = ptr_cell;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_a[AW-1:0]] <= mem_wd;
		rd_q <= mem[mem_a[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			mode_q      <= M_NONE;
			k_q         <= 3'd0;
			clr_q       <= '0;
			pc_q        <= 16'd0;
			stat_q      <= ST_STOP;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!res_valid_q || res_ready)) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						rdata_q <= 16'd0;
						k_q     <= 3'd0;
						mode_q  <= M_NONE;
						unique case (in_data.op)
							OP_WRITE: state_q <= S_MWR;
							OP_READ:  state_q <= S_MRD;
							OP_START: begin
								mode_q  <= M_START;
								state_q <= S_DISP;
							end
							OP_STEP: begin
								if (stat_q == ST_RUN && {1'b0, pc_q} < 17'(MEM_WORDS)) begin
									mode_q  <= M_STEP;
									state_q <= S_FETCH0;
								end else begin
									if (stat_q == ST_RUN) stat_q <= ST_STOP;
									state_q <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_MWR:    state_q <= S_FIN;
				S_MRD:    state_q <= S_MRD2;
				S_MRD2: begin
					rdata_q <= rd_q;
					state_q <= S_FIN;
				end
				S_FETCH0: state_q <= S_FETCH1;
				S_FETCH1: begin
					w_q     <= rd_q;
					state_q <= S_DISP;
				end
				S_DISP: begin
					unique case (u.kind)
						U_RD:    state_q <= S_R0;
						U_WR:    state_q <= S_W0;
						U_PUSH:  state_q <= S_U0;
						U_POP:   state_q <= S_O0;
						default: state_q <= S_FIN;
					endcase
				end
				S_R0: state_q <= S_R1;
				S_R1: begin
					if (u.dst_b) b_q <= rd_q;
					else a_q <= rd_q;
					k_q     <= k_q + 3'd1;
					state_q <= S_DISP;
				end
				S_W0: begin
					k_q     <= k_q + 3'd1;
					state_q <= S_DISP;
				end
				S_U0: state_q <= S_U1;
				S_U1: state_q <= S_U2;
				S_U2: state_q <= S_U3;
				S_U3: begin
					k_q     <= k_q + 3'd1;
					state_q <= S_DISP;
				end
				S_O0: state_q <= S_O1;
				S_O1: state_q <= S_O2;
				S_O2: state_q <= S_O3;
				S_O3: state_q <= S_O4;
				S_O4: begin
					if (u.dst_b) b_q <= rd_q;
					else a_q <= rd_q;
					k_q     <= k_q + 3'd1;
					state_q <= S_DISP;
				end
				S_FIN: begin
					if (mode_q == M_START) begin
						pc_q   <= item_q.addr;
						stat_q <= ({1'b0, item_q.addr} < 17'(MEM_WORDS)) ? ST_RUN : ST_STOP;
					end else if (mode_q == M_STEP) begin
						pc_q <= pcn;
						if (w_q == I_HALT) stat_q <= ST_HALT;
						else stat_q <= ({1'b0, pcn} < 17'(MEM_WORDS)) ? ST_RUN : ST_STOP;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_q.rdata      <= rdata_q;
						res_q.pc_now     <= pc_q;
						res_q.status     <= stat_q;
						res_q.out_valid  <= (mode_q == M_STEP && w_q == I_PUTC);
						res_q.out_char   <= (mode_q == M_STEP && w_q == I_PUTC) ? a_q[7:0] : 8'd0;
						res_q.char_taken <= (mode_q == M_STEP && w_q == I_GETC);
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status != 2'd3)
		else $error("illegal status code");

	a_char_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.out_valid) |-> res_data.out_char == 8'd0)
		else $error("out_char set without PUTC");

	a_io_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.out_valid && res_data.char_taken))
		else $error("PUTC and GETC in one transaction");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output stage");

endmodule
